// ===== hdl/u8sd_pkg.sv =====
// u8sd_pkg: shared types and constants of the utf-8 stream decoder
// used by the front, queue, back and top-level modules
`default_nettype none

package u8sd_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned UsedWidth  = 3;
  localparam int unsigned OutCount   = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [CpWidth-1:0] ReplReset  = 21'h00FFFD;
  localparam logic [CpWidth-1:0] MinTwo     = 21'h000080;
  localparam logic [CpWidth-1:0] MinThree   = 21'h000800;
  localparam logic [CpWidth-1:0] SurrLow    = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrHigh   = 21'h00DFFF;
  localparam logic [CpWidth-1:0] MinFour    = 21'h010000;
  localparam logic [CpWidth-1:0] MaxScalar  = 21'h10FFFF;

  localparam logic [UsedWidth-1:0] LenNone  = 3'd0;
  localparam logic [UsedWidth-1:0] LenOne   = 3'd1;
  localparam logic [UsedWidth-1:0] LenTwo   = 3'd2;
  localparam logic [UsedWidth-1:0] LenThree = 3'd3;
  localparam logic [UsedWidth-1:0] LenFour  = 3'd4;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_DATA,
    TAIL_REP,
    TAIL_END
  } tail_e;

  // one queued command: rep_cnt replacements, then the tail item
  typedef struct packed {
    logic [2:0]           rep_cnt;
    tail_e                tail;
    logic [CpWidth-1:0]   cp;
    logic [UsedWidth-1:0] used;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/u8sd_front.sv =====
// u8sd_front: byte classifier and sequence tracker of the utf-8 decoder
// turns each accepted byte into at most one command; depends on u8sd_pkg
`default_nettype none

module u8sd_front import u8sd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire logic [ByteWidth-1:0] byte_i,
  output logic                      push_o,
  output cmd_t                      cmd_o
);

  logic [UsedWidth-1:0] exp_q, exp_d;
  logic [1:0]           held_q, held_d;
  logic [CpWidth-1:0]   acc_q, acc_d;

  logic                 is_cont;
  logic [CpWidth-1:0]   acc_new;
  logic [1:0]           held_new;
  logic                 cp_ok;
  cmd_t                 cmd;

  assign is_cont  = (byte_i[7:6] == 2'b10);
  assign acc_new  = {acc_q[CpWidth-7:0], byte_i[5:0]};
  assign held_new = held_q + 2'd1;

  always_comb begin
    case (exp_q)
      LenTwo:   cp_ok = (acc_new >= MinTwo);
      LenThree: cp_ok = (acc_new >= MinThree) && !((acc_new >= SurrLow) && (acc_new <= SurrHigh));
      LenFour:  cp_ok = (acc_new >= MinFour) && (acc_new <= MaxScalar);
      default:  cp_ok = 1'b0;
    endcase
  end

  always_comb begin
    exp_d       = exp_q;
    held_d      = held_q;
    acc_d       = acc_q;
    cmd.rep_cnt = 3'd0;
    cmd.tail    = TAIL_NONE;
    cmd.cp      = '0;
    cmd.used    = LenNone;
    if ((exp_q != LenNone) && is_cont) begin
      if ({1'b0, held_new} + 3'd1 >= exp_q) begin
        exp_d  = LenNone;
        held_d = 2'd0;
        acc_d  = '0;
        if (cp_ok) begin
          cmd.tail = TAIL_DATA;
          cmd.cp   = acc_new;
          cmd.used = exp_q;
        end else begin
          cmd.rep_cnt = exp_q;
        end
      end else begin
        held_d = held_new;
        acc_d  = acc_new;
      end
    end else begin
      // broken sequence: lead and held bytes flush first
      if (exp_q != LenNone) begin
        cmd.rep_cnt = {1'b0, held_q} + 3'd1;
      end
      exp_d  = LenNone;
      held_d = 2'd0;
      acc_d  = '0;
      if (byte_i == '0) begin
        cmd.tail = TAIL_END;
      end else if (!byte_i[7]) begin
        cmd.tail = TAIL_DATA;
        cmd.cp   = {{(CpWidth-ByteWidth){1'b0}}, byte_i};
        cmd.used = LenOne;
      end else if (byte_i[7:5] == 3'b110) begin
        exp_d = LenTwo;
        acc_d = {{(CpWidth-5){1'b0}}, byte_i[4:0]};
      end else if (byte_i[7:4] == 4'b1110) begin
        exp_d = LenThree;
        acc_d = {{(CpWidth-4){1'b0}}, byte_i[3:0]};
      end else if (byte_i[7:3] == 5'b11110) begin
        exp_d = LenFour;
        acc_d = {{(CpWidth-3){1'b0}}, byte_i[2:0]};
      end else begin
        cmd.tail = TAIL_REP;
      end
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept_i && ((cmd.rep_cnt != 3'd0) || (cmd.tail != TAIL_NONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= LenNone;
      held_q <= 2'd0;
      acc_q  <= '0;
    end else if (accept_i) begin
      exp_q  <= exp_d;
      held_q <= held_d;
      acc_q  <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/u8sd_queue.sv =====
// u8sd_queue: small command queue between front and back of the decoder
// flip-flop storage, first-word fall-through; depends on u8sd_pkg
`default_nettype none

module u8sd_queue import u8sd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      head_valid_o,
  output cmd_t      head_o
);

  cmd_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   fill_q;

  assign full_o       = (fill_q == QueueDepth[QueuePtrW:0]);
  assign head_valid_o = (fill_q != '0);
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/u8sd_back.sv =====
// u8sd_back: expands queued commands into result transfers, keeps the count
// owns the output register; depends on u8sd_pkg
`default_nettype none

module u8sd_back import u8sd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [CpWidth-1:0] repl_i,
  input  wire logic               head_valid_i,
  input  cmd_t                    head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [CpWidth-1:0]      out_cp_o,
  output logic                    out_rep_o,
  output logic [UsedWidth-1:0]    out_used_o,
  output logic                    out_end_o,
  output logic [OutCount-1:0]     out_count_o,
  output logic                    out_last_o
);

  logic [1:0]            sub_q, sub_d;
  logic [COUNT_BITS-1:0] count_q, count_d, count_inc;
  logic                  valid_q;
  logic [CpWidth-1:0]    cp_q, cp_d;
  logic                  rep_q, rep_d;
  logic [UsedWidth-1:0]  used_q, used_d;
  logic                  end_q, end_d;
  logic [OutCount-1:0]   cnt_q, cnt_d;
  logic                  last_q;

  logic                  load;
  logic                  is_rep_item;
  logic                  item_last;
  logic [2:0]            total;
  logic [COUNT_BITS+OutCount-1:0] count_ext;

  assign load        = head_valid_i && (!valid_q || out_ready_i);
  assign total       = head_i.rep_cnt + ((head_i.tail != TAIL_NONE) ? 3'd1 : 3'd0);
  assign is_rep_item = ({1'b0, sub_q} < head_i.rep_cnt);
  assign item_last   = ({1'b0, sub_q} + 3'd1 == total);
  assign count_inc   = (&count_q) ? count_q : count_q + 1'b1;
  assign pop_o       = load && item_last;

  always_comb begin
    cp_d    = repl_i;
    rep_d   = 1'b1;
    used_d  = LenOne;
    end_d   = 1'b0;
    count_d = count_inc;
    if (!is_rep_item) begin
      case (head_i.tail)
        TAIL_DATA: begin
          cp_d   = head_i.cp;
          rep_d  = 1'b0;
          used_d = head_i.used;
        end
        TAIL_END: begin
          cp_d    = '0;
          rep_d   = 1'b0;
          used_d  = LenNone;
          end_d   = 1'b1;
          count_d = '0;
        end
        default: begin
          cp_d = repl_i;
        end
      endcase
    end
    count_ext = {{OutCount{1'b0}}, (end_d ? count_q : count_inc)};
    cnt_d     = count_ext[OutCount-1:0];
    sub_d     = item_last ? 2'd0 : sub_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 2'd0;
      count_q <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        sub_q   <= sub_d;
        count_q <= count_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= cp_d;
      rep_q  <= rep_d;
      used_q <= used_d;
      end_q  <= end_d;
      cnt_q  <= cnt_d;
      last_q <= item_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_cp_o    = cp_q;
  assign out_rep_o   = rep_q;
  assign out_used_o  = used_q;
  assign out_end_o   = end_q;
  assign out_count_o = cnt_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ===== hdl/utf8_stream_decoder.sv =====
// utf8_stream_decoder: utf-8 decoder with replacement, top level
// depends on u8sd_pkg, u8sd_front, u8sd_queue and u8sd_back
//
// usage: text bytes enter on the s_axis group, one byte per transfer, a zero
// byte ends the text. each byte causes zero to four result transfers on the
// m_axis group: decoded code points, replacements for rejected bytes, and on
// the terminator one end item with the code point count of the text. tlast
// marks the final result caused by a byte. the cfg channel writes the
// replacement code; it is always ready. the user sees that it is written
// only while the block idles; the block does not enforce it. commands pass
// through the queue to the output register. throughput while the receiver
// is ready: one byte per cycle while each byte causes at most one result;
// the output register emits one result per cycle, and the four-entry
// command queue absorbs bursts. s_axis_tready drops only while it is full.
// reset: no sequence open, count zero, replacement code 0xFFFD, queue empty.
// when the receiver stalls, the output holds and the queue fills behind it.
`default_nettype none

module utf8_stream_decoder import u8sd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CpWidth-1:0]   cfg_data_i,     // replacement_code
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] text_byte
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [55:0]               m_axis_tdata,   // [20:0] code_point, [23:21] bytes_used,
                                                    // [55:24] point_count
  output logic [1:0]                m_axis_tuser,   // [0] replaced, [1] text_end
  output logic                      m_axis_tlast    // last_of_run
);

  logic [CpWidth-1:0]   repl_q;
  logic                 accept;
  logic                 push;
  cmd_t                 push_cmd;
  logic                 q_full;
  logic                 pop;
  logic                 head_valid;
  cmd_t                 head;
  logic [CpWidth-1:0]   out_cp;
  logic                 out_rep;
  logic [UsedWidth-1:0] out_used;
  logic                 out_end;
  logic [OutCount-1:0]  out_count;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= ReplReset;
    end else if (cfg_valid_i) begin
      repl_q <= cfg_data_i;
    end
  end

  u8sd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  u8sd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  u8sd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .repl_i       (repl_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_cp_o     (out_cp),
    .out_rep_o    (out_rep),
    .out_used_o   (out_used),
    .out_end_o    (out_end),
    .out_count_o  (out_count),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_count, out_used, out_cp};
  assign m_axis_tuser = {out_end, out_rep};

endmodule

`default_nettype wire

// ===== tb/sv/utf8_decode_checker.sv =====
// utf8_decode_checker: watches the config, byte and result channels of the utf-8
// stream decoder, predicts each result and compares it field by field
// depends on u8sd_pkg; instantiated beside the decoder by utf8_stream_decoder_tb
`default_nettype none

module utf8_decode_checker import u8sd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [CpWidth-1:0] cfg_data_i,
  input  wire logic               s_axis_tvalid,
  input  wire logic               s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,    // [7:0] text_byte
  input  wire logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  input  wire logic [55:0]        m_axis_tdata,    // [20:0] code_point, [23:21] bytes_used,
                                                   // [55:24] point_count
  input  wire logic [1:0]         m_axis_tuser,    // [0] replaced, [1] text_end
  input  wire logic               m_axis_tlast,    // last_of_run
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CpWidth-1:0]   code_point;
    logic                 replaced;
    logic [UsedWidth-1:0] bytes_used;
    logic                 text_end;
    logic [31:0]          point_count;
    logic                 last_of_run;
  } decoded_t;

  decoded_t             points_q[$];
  logic [CpWidth-1:0]   repl_code;
  logic [UsedWidth-1:0] seq_len;
  logic [1:0]           held;
  logic [CpWidth-1:0]   payload;
  logic [31:0]          text_total;
  int unsigned          run_n;
  int unsigned          errors;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    errors       = 0;
  end

  task automatic emit(input logic [CpWidth-1:0] cp, input logic rep,
                      input logic [UsedWidth-1:0] used, input logic fin);
    decoded_t r;
    if (run_n < 4) begin
      if (!fin && text_total != '1) text_total++;
      r.code_point  = cp;
      r.replaced    = rep;
      r.bytes_used  = used;
      r.text_end    = fin;
      r.point_count = text_total;
      r.last_of_run = 1'b0;
      points_q.push_back(r);
      run_n++;
    end
  endtask

  // lead byte and every held continuation become replacements
  task automatic drop_seq();
    emit(repl_code, 1'b1, LenOne, 1'b0);
    for (int k = 0; k < held; k++) emit(repl_code, 1'b1, LenOne, 1'b0);
    seq_len = LenNone;
    held    = '0;
    payload = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int   first;
    logic ok;
    first = points_q.size();
    run_n = 0;
    if (seq_len != LenNone && b[7:6] == 2'b10) begin
      payload = {payload[CpWidth-7:0], b[5:0]};
      held    = held + 2'd1;
      if (3'(held) + 3'd1 >= seq_len) begin
        case (seq_len)
          LenTwo:   ok = payload >= MinTwo;
          LenThree: ok = payload >= MinThree && !(payload >= SurrLow && payload <= SurrHigh);
          default:  ok = payload >= MinFour && payload <= MaxScalar;
        endcase
        if (ok) begin
          emit(payload, 1'b0, seq_len, 1'b0);
          seq_len = LenNone;
          held    = '0;
          payload = '0;
        end else begin
          drop_seq();
        end
      end
    end else begin
      if (seq_len != LenNone) drop_seq();
      if (b == 8'h00) begin
        emit('0, 1'b0, LenNone, 1'b1);
        text_total = '0;
      end else if (!b[7]) begin
        emit(CpWidth'(b), 1'b0, LenOne, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        seq_len = LenTwo;
        held    = '0;
        payload = CpWidth'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        seq_len = LenThree;
        held    = '0;
        payload = CpWidth'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        seq_len = LenFour;
        held    = '0;
        payload = CpWidth'(b[2:0]);
      end else begin
        emit(repl_code, 1'b1, LenOne, 1'b0);
      end
    end
    if (points_q.size() > first) points_q[$].last_of_run = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    decoded_t want;
    if (!rst_ni) begin
      repl_code  = ReplReset;
      seq_len    = LenNone;
      held       = '0;
      payload    = '0;
      text_total = '0;
      points_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) repl_code = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (points_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual code point %0h",
                   $time, m_axis_tdata[20:0]);
          errors++;
        end else begin
          want = points_q.pop_front();
          check_field("code_point", 32'(want.code_point), 32'(m_axis_tdata[20:0]));
          check_field("replaced", 32'(want.replaced), 32'(m_axis_tuser[0]));
          check_field("bytes_used", 32'(want.bytes_used), 32'(m_axis_tdata[23:21]));
          check_field("text_end", 32'(want.text_end), 32'(m_axis_tuser[1]));
          check_field("point_count", want.point_count, m_axis_tdata[55:24]);
          check_field("last_of_run", 32'(want.last_of_run), 32'(m_axis_tlast));
        end
      end
    end
    pending_o    <= points_q.size();
    fail_count_o <= errors;
  end

endmodule

`default_nettype wire

// ===== tb/sv/utf8_stream_decoder_tb.sv =====
// utf8_stream_decoder_tb: drives text bytes, replacement code writes and
// receiver stalls into the utf-8 stream decoder and gives the verdict
// depends on u8sd_pkg, utf8_stream_decoder and utf8_decode_checker
`default_nettype none

module utf8_stream_decoder_tb import u8sd_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CpWidth-1:0] cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;    // [7:0] text_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [55:0]        m_axis_tdata;    // [20:0] code_point, [23:21] bytes_used, [55:24] point_count
  logic [1:0]         m_axis_tuser;    // [0] replaced, [1] text_end
  logic               m_axis_tlast;    // last_of_run

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_sent;
  logic        idle_on;

  utf8_stream_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  utf8_decode_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // receiver stalls
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  // sender holds off until every result is out and the pipeline is quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_repl(input logic [CpWidth-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'(8'h80 + $urandom_range(0, 'h3F));
  endfunction

  // one piece of text: mostly a well-formed sequence, else a terminator, a broken sequence or noise
  task automatic send_piece();
    logic [7:0]   seq_b [4];
    logic [20:0]  cp;
    int unsigned  len;
    int unsigned  kind;
    int unsigned  pick;
    kind = $urandom_range(0, 99);
    len  = $urandom_range(1, 4);
    case (len)
      1: cp = 21'($urandom_range(1, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= SurrLow && cp <= SurrHigh) cp = cp ^ 21'h2000;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    case (len)
      1: seq_b[0] = cp[7:0];
      2: begin
        seq_b[0] = {3'b110, cp[10:6]};
        seq_b[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq_b[0] = {4'b1110, cp[15:12]};
        seq_b[1] = {2'b10, cp[11:6]};
        seq_b[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq_b[0] = {5'b11110, cp[20:18]};
        seq_b[1] = {2'b10, cp[17:12]};
        seq_b[2] = {2'b10, cp[11:6]};
        seq_b[3] = {2'b10, cp[5:0]};
      end
    endcase
    if (kind < 55) begin
    end else if (kind < 62) begin
      len      = 1;
      seq_b[0] = 8'h00;
    end else if (kind < 70) begin
      len      = 1;
      seq_b[0] = $urandom_range(0, 1) ? cont_byte() : 8'(8'hF8 + $urandom_range(0, 7));
    end else if (kind < 78) begin
      if (len > 1) len = $urandom_range(1, len - 1);
    end else if (kind < 88) begin
      pick = $urandom_range(0, 3);
      case (pick)
        0: begin
          len      = 2;
          seq_b[0] = 8'(8'hC0 + $urandom_range(0, 1));
          seq_b[1] = cont_byte();
        end
        1: begin
          len      = 3;
          seq_b[0] = 8'hE0;
          seq_b[1] = 8'(8'h80 + $urandom_range(0, 'h1F));
          seq_b[2] = cont_byte();
        end
        2: begin
          len      = 4;
          seq_b[0] = 8'hF0;
          seq_b[1] = 8'(8'h80 + $urandom_range(0, 'h0F));
          seq_b[2] = cont_byte();
          seq_b[3] = cont_byte();
        end
        default: begin
          len      = 4;
          seq_b[0] = 8'(8'hF4 + $urandom_range(0, 3));
          seq_b[1] = 8'(8'h90 + $urandom_range(0, 'h2F));
          seq_b[2] = cont_byte();
          seq_b[3] = cont_byte();
        end
      endcase
    end else if (kind < 94) begin
      len      = 3;
      seq_b[0] = 8'hED;
      seq_b[1] = 8'(8'hA0 + $urandom_range(0, 'h1F));
      seq_b[2] = cont_byte();
    end else begin
      len      = 1;
      seq_b[0] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < len; i++) push_byte(seq_b[i]);
  endtask

  initial begin
    logic [7:0]         opening [$];
    logic [CpWidth-1:0] repl_values [5];
    int unsigned        phase_start;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    idle_on       <= 1'b0;
    bytes_sent    = 0;
    repl_values   = '{21'h000000, 21'h1FFFFF, MaxScalar, 21'($urandom_range(0, 'h1FFFFF)),
                      ReplReset};
    // ascii top, two byte floor, three byte ceiling, highest scalar, lone continuation,
    // invalid byte, overlong two byte, surrogate, above range, early cut by
    // ascii, early cut by the terminator
    opening = '{8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                8'h80, 8'hFF, 8'hC1, 8'hBF, 8'hED, 8'hA0, 8'h80, 8'hF5, 8'h80, 8'h80,
                8'h80, 8'hE2, 8'h82, 8'h41, 8'hF0, 8'h90, 8'h00};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening[i]) push_byte(opening[i]);
    for (int p = 0; p < 5; p++) begin
      settle();
      write_repl(repl_values[p]);
      idle_on     <= (p != 4);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 60) send_piece();
    end
    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== utf8_stream_decoder.f =====
hdl/u8sd_pkg.sv
hdl/u8sd_front.sv
hdl/u8sd_queue.sv
hdl/u8sd_back.sv
hdl/utf8_stream_decoder.sv
tb/sv/utf8_decode_checker.sv
tb/sv/utf8_stream_decoder_tb.sv
